// ===== src/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants for the midpoint ellipse rasterizer: command
// and region tag codes, datapath operation and multiplier select codes, and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 11;

    // Input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Region tag codes on the result
    localparam logic REGION_ONE = 1'b0;
    localparam logic REGION_TWO = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_RX_SQ,
        OP_RY_SQ,
        OP_INIT,
        OP_ACC_LOAD,
        OP_ACC_ADD,
        OP_ACC_SUB,
        OP_STEP1,
        OP_STEP2
    } dp_op_t;

    typedef enum logic [2:0] {
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_RXSQ_RY,
        MUL_HX_HX,
        MUL_PROD_RYSQ,
        MUL_YM_YM,
        MUL_PROD_RXSQ,
        MUL_RXSQ_RYSQ
    } mul_sel_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t mul_sel;
        logic     load_out;
        logic     res_valid;
        logic     res_region;
    } dp_cmd_t;

    typedef struct packed {
        logic y_zero;
        logic reg1_go;
    } dp_status_t;

endpackage

// ===== src/mer_datapath.sv =====
// ----------------------------------------------------------------------------
// mer_datapath
// Ellipse state registers, one shared registered multiplier, the decision
// variable update adders and the result register.
// ----------------------------------------------------------------------------
module mer_datapath #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mer_pkg::dp_cmd_t              cmd,
    output mer_pkg::dp_status_t           status,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic [RADIUS_BITS-1:0]        radius_x,
    input  logic [RADIUS_BITS-1:0]        radius_y,
    output logic signed [COORD_BITS+1:0]  x_right,
    output logic signed [COORD_BITS+1:0]  x_left,
    output logic signed [COORD_BITS+1:0]  y_lower,
    output logic signed [COORD_BITS+1:0]  y_upper,
    output logic                          region,
    output logic                          points_valid,
    output logic                          last
);

    localparam int OFS_W  = RADIUS_BITS + 1;
    localparam int SQ_W   = 2 * RADIUS_BITS;
    localparam int TERM_W = 3 * RADIUS_BITS + 2;
    localparam int DEC_W  = 4 * RADIUS_BITS + 4;
    localparam int MUL_W  = 2 * RADIUS_BITS + 4;
    localparam int PROD_W = 2 * MUL_W;
    localparam int OUT_W  = COORD_BITS + 2;
    localparam int EXT_W  = ((COORD_BITS > OFS_W) ? COORD_BITS : OFS_W) + 2;

    function automatic logic [DEC_W-1:0] times4(input logic [DEC_W-1:0] v);
        times4 = {v[DEC_W-3:0], 2'b00};
    endfunction

    logic [COORD_BITS-1:0]  centre_col_reg, centre_col_next;
    logic [COORD_BITS-1:0]  centre_row_reg, centre_row_next;
    logic [RADIUS_BITS-1:0] rx_reg, rx_next;
    logic [RADIUS_BITS-1:0] ry_reg, ry_next;
    logic [SQ_W-1:0]        rx_sq_reg, rx_sq_next;
    logic [SQ_W-1:0]        ry_sq_reg, ry_sq_next;
    logic [OFS_W-1:0]       offset_x_reg, offset_x_next;
    logic [OFS_W-1:0]       offset_y_reg, offset_y_next;
    logic [DEC_W-1:0]       dec_reg, dec_next;
    logic [TERM_W-1:0]      ry2x_reg, ry2x_next;
    logic [TERM_W-1:0]      rx2y_reg, rx2y_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;

    logic [OUT_W-1:0] x_right_reg, x_left_reg, y_lower_reg, y_upper_reg;
    logic             region_reg, points_valid_reg, last_reg;

    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [OFS_W:0]    hx;
    logic [OFS_W-1:0]  ym;
    logic [TERM_W-1:0] two_rx_sq, two_ry_sq, ry2x_step, rx2y_step;
    logic [DEC_W-1:0]  rx_sq_e, ry_sq_e, prod_e, ry2x_step_e, rx2y_step_e;
    logic [DEC_W-1:0]  inc_r1, inc_r2;
    logic              dec_neg, dec_zero;
    logic [EXT_W-1:0]  col_e, row_e, ox_e, oy_e;
    logic [EXT_W-1:0]  xr_sum, xl_sum, yl_sum, yu_sum;

    // Shared multiplier operand select
    assign hx = {offset_x_reg, 1'b1};
    assign ym = offset_y_reg - OFS_W'(1);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            mer_pkg::MUL_RX_RX:
            begin
                mul_a = MUL_W'(rx_reg);
                mul_b = MUL_W'(rx_reg);
            end
            mer_pkg::MUL_RY_RY:
            begin
                mul_a = MUL_W'(ry_reg);
                mul_b = MUL_W'(ry_reg);
            end
            mer_pkg::MUL_RXSQ_RY:
            begin
                mul_a = MUL_W'(rx_sq_reg);
                mul_b = MUL_W'(ry_reg);
            end
            mer_pkg::MUL_HX_HX:
            begin
                mul_a = MUL_W'(hx);
                mul_b = MUL_W'(hx);
            end
            mer_pkg::MUL_PROD_RYSQ:
            begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = MUL_W'(ry_sq_reg);
            end
            mer_pkg::MUL_YM_YM:
            begin
                mul_a = MUL_W'(ym);
                mul_b = MUL_W'(ym);
            end
            mer_pkg::MUL_PROD_RXSQ:
            begin
                mul_a = prod_reg[MUL_W-1:0];
                mul_b = MUL_W'(rx_sq_reg);
            end
            mer_pkg::MUL_RXSQ_RYSQ:
            begin
                mul_a = MUL_W'(rx_sq_reg);
                mul_b = MUL_W'(ry_sq_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Incremental terms
    assign two_rx_sq   = {{(TERM_W-SQ_W-1){1'b0}}, rx_sq_reg, 1'b0};
    assign two_ry_sq   = {{(TERM_W-SQ_W-1){1'b0}}, ry_sq_reg, 1'b0};
    assign ry2x_step   = ry2x_reg + two_ry_sq;
    assign rx2y_step   = rx2y_reg - two_rx_sq;
    assign rx_sq_e     = {{(DEC_W-SQ_W){1'b0}}, rx_sq_reg};
    assign ry_sq_e     = {{(DEC_W-SQ_W){1'b0}}, ry_sq_reg};
    assign prod_e      = prod_reg[DEC_W-1:0];
    assign ry2x_step_e = {{(DEC_W-TERM_W){1'b0}}, ry2x_step};
    assign rx2y_step_e = {{(DEC_W-TERM_W){1'b0}}, rx2y_step};
    assign dec_neg     = dec_reg[DEC_W-1];
    assign dec_zero    = (dec_reg == '0);

    assign inc_r1 = dec_neg ? (ry2x_step_e + ry_sq_e)
                            : (ry2x_step_e - rx2y_step_e + ry_sq_e);
    assign inc_r2 = (!dec_zero && !dec_neg) ? (rx_sq_e - rx2y_step_e)
                                            : (ry2x_step_e - rx2y_step_e + rx_sq_e);

    always_comb
    begin
        centre_col_next = centre_col_reg;
        centre_row_next = centre_row_reg;
        rx_next         = rx_reg;
        ry_next         = ry_reg;
        rx_sq_next      = rx_sq_reg;
        ry_sq_next      = ry_sq_reg;
        offset_x_next   = offset_x_reg;
        offset_y_next   = offset_y_reg;
        dec_next        = dec_reg;
        ry2x_next       = ry2x_reg;
        rx2y_next       = rx2y_reg;
        unique case (cmd.op)
            mer_pkg::OP_NONE:
            begin
                dec_next = dec_reg;
            end
            mer_pkg::OP_START:
            begin
                centre_col_next = center_x;
                centre_row_next = center_y;
                rx_next         = radius_x;
                ry_next         = radius_y;
                offset_x_next   = '0;
                offset_y_next   = OFS_W'(radius_y);
                ry2x_next       = '0;
            end
            mer_pkg::OP_RX_SQ:
            begin
                rx_sq_next = prod_reg[SQ_W-1:0];
            end
            mer_pkg::OP_RY_SQ:
            begin
                ry_sq_next = prod_reg[SQ_W-1:0];
            end
            mer_pkg::OP_INIT:
            begin
                rx2y_next = {prod_reg[TERM_W-2:0], 1'b0};
                dec_next  = times4(ry_sq_e) - times4(prod_e) + rx_sq_e;
            end
            mer_pkg::OP_ACC_LOAD:
            begin
                dec_next = prod_e;
            end
            mer_pkg::OP_ACC_ADD:
            begin
                dec_next = dec_reg + times4(prod_e);
            end
            mer_pkg::OP_ACC_SUB:
            begin
                dec_next = dec_reg - times4(prod_e);
            end
            mer_pkg::OP_STEP1:
            begin
                offset_x_next = offset_x_reg + OFS_W'(1);
                ry2x_next     = ry2x_step;
                dec_next      = dec_reg + times4(inc_r1);
                if (!dec_neg)
                begin
                    offset_y_next = offset_y_reg - OFS_W'(1);
                    rx2y_next     = rx2y_step;
                end
            end
            mer_pkg::OP_STEP2:
            begin
                offset_y_next = offset_y_reg - OFS_W'(1);
                rx2y_next     = rx2y_step;
                dec_next      = dec_reg + times4(inc_r2);
                if (dec_zero || dec_neg)
                begin
                    offset_x_next = offset_x_reg + OFS_W'(1);
                    ry2x_next     = ry2x_step;
                end
            end
            default:
            begin
                dec_next = dec_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_col_reg <= '0;
            centre_row_reg <= '0;
            rx_reg         <= '0;
            ry_reg         <= '0;
            rx_sq_reg      <= '0;
            ry_sq_reg      <= '0;
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
            dec_reg        <= '0;
            ry2x_reg       <= '0;
            rx2y_reg       <= '0;
        end
        else
        begin
            centre_col_reg <= centre_col_next;
            centre_row_reg <= centre_row_next;
            rx_reg         <= rx_next;
            ry_reg         <= ry_next;
            rx_sq_reg      <= rx_sq_next;
            ry_sq_reg      <= ry_sq_next;
            offset_x_reg   <= offset_x_next;
            offset_y_reg   <= offset_y_next;
            dec_reg        <= dec_next;
            ry2x_reg       <= ry2x_next;
            rx2y_reg       <= rx2y_next;
        end
    end

    // Product register: no reset, every product is written before it is used
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Four symmetric points, wrapped to the output width
    assign col_e  = {{(EXT_W-COORD_BITS){1'b0}}, centre_col_reg};
    assign row_e  = {{(EXT_W-COORD_BITS){1'b0}}, centre_row_reg};
    assign ox_e   = {{(EXT_W-OFS_W){1'b0}}, offset_x_reg};
    assign oy_e   = {{(EXT_W-OFS_W){1'b0}}, offset_y_reg};
    assign xr_sum = col_e + ox_e;
    assign xl_sum = col_e - ox_e;
    assign yl_sum = row_e + oy_e;
    assign yu_sum = row_e - oy_e;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (cmd.res_valid)
            begin
                x_right_reg      <= xr_sum[OUT_W-1:0];
                x_left_reg       <= xl_sum[OUT_W-1:0];
                y_lower_reg      <= yl_sum[OUT_W-1:0];
                y_upper_reg      <= yu_sum[OUT_W-1:0];
                region_reg       <= cmd.res_region;
                points_valid_reg <= 1'b1;
                last_reg         <= (offset_y_reg == '0);
            end
            else
            begin
                x_right_reg      <= '0;
                x_left_reg       <= '0;
                y_lower_reg      <= '0;
                y_upper_reg      <= '0;
                region_reg       <= 1'b0;
                points_valid_reg <= 1'b0;
                last_reg         <= 1'b0;
            end
        end
    end

    assign x_right      = x_right_reg;
    assign x_left       = x_left_reg;
    assign y_lower      = y_lower_reg;
    assign y_upper      = y_upper_reg;
    assign region       = region_reg;
    assign points_valid = points_valid_reg;
    assign last         = last_reg;

    assign status.y_zero  = (offset_y_reg == '0);
    assign status.reg1_go = (ry2x_reg < rx2y_reg);

endmodule

// ===== src/mer_ctrl.sv =====
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer for the rasterizer: input and output handshakes, the ellipse
// phase, and the multiply sequences for start and for the region change.
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    output logic                out_valid,
    input  logic                out_ready,
    input  mer_pkg::dp_status_t status,
    output mer_pkg::dp_cmd_t    cmd
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_SQ_RX   = 13'b0000000000010,
        S_SQ_RY   = 13'b0000000000100,
        S_INIT_M  = 13'b0000000001000,
        S_INIT_D  = 13'b0000000010000,
        S_CHG_HX  = 13'b0000000100000,
        S_CHG_A   = 13'b0000001000000,
        S_CHG_YM  = 13'b0000010000000,
        S_CHG_B   = 13'b0000100000000,
        S_CHG_RR  = 13'b0001000000000,
        S_CHG_D   = 13'b0010000000000,
        S_R2_STEP = 13'b0100000000000,
        S_EMIT    = 13'b1000000000000
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_REG1 = 2'd1,
        PH_REG2 = 2'd2
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   res_valid_reg, res_valid_next;
    logic   res_region_reg, res_region_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        res_valid_next  = res_valid_reg;
        res_region_next = res_region_reg;
        out_valid_next  = out_valid_reg;

        cmd.op         = mer_pkg::OP_NONE;
        cmd.mul_sel    = mer_pkg::MUL_RX_RX;
        cmd.load_out   = 1'b0;
        cmd.res_valid  = res_valid_reg;
        cmd.res_region = res_region_reg;

        // Drop the result once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (command == mer_pkg::CMD_START)
                    begin
                        cmd.op          = mer_pkg::OP_START;
                        res_valid_next  = 1'b1;
                        res_region_next = mer_pkg::REGION_ONE;
                        phase_next      = PH_REG1;
                        state_next      = S_SQ_RX;
                    end
                    else if (phase_reg == PH_IDLE || status.y_zero)
                    begin
                        res_valid_next  = 1'b0;
                        res_region_next = mer_pkg::REGION_ONE;
                        phase_next      = PH_IDLE;
                        state_next      = S_EMIT;
                    end
                    else if (phase_reg == PH_REG1 && status.reg1_go)
                    begin
                        cmd.op          = mer_pkg::OP_STEP1;
                        res_valid_next  = 1'b1;
                        res_region_next = mer_pkg::REGION_ONE;
                        state_next      = S_EMIT;
                    end
                    else if (phase_reg == PH_REG1)
                    begin
                        res_valid_next  = 1'b1;
                        res_region_next = mer_pkg::REGION_TWO;
                        phase_next      = PH_REG2;
                        state_next      = S_CHG_HX;
                    end
                    else
                    begin
                        cmd.op          = mer_pkg::OP_STEP2;
                        res_valid_next  = 1'b1;
                        res_region_next = mer_pkg::REGION_TWO;
                        state_next      = S_EMIT;
                    end
                end
            end
            S_SQ_RX:
            begin
                cmd.mul_sel = mer_pkg::MUL_RX_RX;
                state_next  = S_SQ_RY;
            end
            S_SQ_RY:
            begin
                cmd.op      = mer_pkg::OP_RX_SQ;
                cmd.mul_sel = mer_pkg::MUL_RY_RY;
                state_next  = S_INIT_M;
            end
            S_INIT_M:
            begin
                cmd.op      = mer_pkg::OP_RY_SQ;
                cmd.mul_sel = mer_pkg::MUL_RXSQ_RY;
                state_next  = S_INIT_D;
            end
            S_INIT_D:
            begin
                cmd.op     = mer_pkg::OP_INIT;
                state_next = S_EMIT;
            end
            S_CHG_HX:
            begin
                cmd.mul_sel = mer_pkg::MUL_HX_HX;
                state_next  = S_CHG_A;
            end
            S_CHG_A:
            begin
                cmd.mul_sel = mer_pkg::MUL_PROD_RYSQ;
                state_next  = S_CHG_YM;
            end
            S_CHG_YM:
            begin
                cmd.op      = mer_pkg::OP_ACC_LOAD;
                cmd.mul_sel = mer_pkg::MUL_YM_YM;
                state_next  = S_CHG_B;
            end
            S_CHG_B:
            begin
                cmd.mul_sel = mer_pkg::MUL_PROD_RXSQ;
                state_next  = S_CHG_RR;
            end
            S_CHG_RR:
            begin
                cmd.op      = mer_pkg::OP_ACC_ADD;
                cmd.mul_sel = mer_pkg::MUL_RXSQ_RYSQ;
                state_next  = S_CHG_D;
            end
            S_CHG_D:
            begin
                cmd.op     = mer_pkg::OP_ACC_SUB;
                state_next = S_R2_STEP;
            end
            S_R2_STEP:
            begin
                cmd.op     = mer_pkg::OP_STEP2;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    if (res_valid_reg && status.y_zero)
                    begin
                        phase_next = PH_IDLE;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_IDLE;
            res_valid_reg  <= 1'b0;
            res_region_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            res_valid_reg  <= res_valid_next;
            res_region_reg <= res_region_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

// ===== src/midpoint_ellipse_rasterizer_top.sv =====
// Accept to result valid: a plain step or a step while idle passes only S_EMIT; a
// start passes S_SQ_RX, S_SQ_RY, S_INIT_M, S_INIT_D, S_EMIT; the step into region 2
// passes S_CHG_HX to S_CHG_D, S_R2_STEP, S_EMIT. The sequencer holds a single
// transaction at a time; the shared multiplier sets the start and region-change
// lengths. Asynchronous active-low reset returns to idle with no result pending.
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_top
// Midpoint ellipse rasterizer. A start transaction loads centre and radii and
// returns the top and bottom points; each step transaction advances one pixel
// and returns the four symmetric points with a region tag.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_top #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic [RADIUS_BITS-1:0]        radius_x,
    input  logic [RADIUS_BITS-1:0]        radius_y,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_BITS+1:0]  x_right,
    output logic signed [COORD_BITS+1:0]  x_left,
    output logic signed [COORD_BITS+1:0]  y_lower,
    output logic signed [COORD_BITS+1:0]  y_upper,
    output logic                          region,
    output logic                          points_valid,
    output logic                          last
);

    // Controller to datapath: one command bundle per cycle, status back.
    // The result register lives in the datapath; the controller owns its
    // valid flag, so a waiting result does not block new input once the
    // sequencer is back in idle.
    mer_pkg::dp_cmd_t    cmd;
    mer_pkg::dp_status_t status;

    mer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: ellipse state, shared multiplier for the squared radii and the
    // start values of both regions, adders for the per-step decision update.
    mer_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius_x     (radius_x),
        .radius_y     (radius_y),
        .x_right      (x_right),
        .x_left       (x_left),
        .y_lower      (y_lower),
        .y_upper      (y_upper),
        .region       (region),
        .points_valid (points_valid),
        .last         (last)
    );

endmodule

// ===== dv/midpoint_ellipse_rasterizer_top_tb.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_top_tb
// Self-checking bench for the midpoint ellipse rasterizer. A short directed
// table hits reset, extreme centres and radii, zero radii, the region change,
// an early finish in region 1 and a start that aborts a running ellipse. A
// random run of mostly complete or cut-short ellipses follows, with stray
// steps mixed in. A bit-true tracer predicts every point set, and random
// valid and ready gaps exercise both sides of each channel.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_top_tb;

    localparam int CB            = mer_pkg::COORD_BITS_DEF;
    localparam int RB            = mer_pkg::RADIUS_BITS_DEF;
    localparam int OUT_W         = CB + 2;
    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_ITEMS  = 950;
    localparam int DRAIN_CYCLES  = 16;
    localparam int LIMIT_CYCLES  = 400000;

    // One point set as it leaves the block
    typedef struct packed {
        logic [OUT_W-1:0] xr;
        logic [OUT_W-1:0] xl;
        logic [OUT_W-1:0] yl;
        logic [OUT_W-1:0] yu;
        logic             rgn;
        logic             pv;
        logic             fin;
    } plot_t;

    // One row of the directed table; want is used only when typed is set
    typedef struct packed {
        logic          cmd;
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic [RB-1:0] rx;
        logic [RB-1:0] ry;
        logic          typed;
        plot_t         want;
    } stim_row_t;

    typedef enum logic [1:0] {
        TRACE_IDLE,
        TRACE_REG1,
        TRACE_REG2
    } trace_phase_t;

    localparam plot_t IDLE_PLOT = '0;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    command;
    logic [CB-1:0]           center_x;
    logic [CB-1:0]           center_y;
    logic [RB-1:0]           radius_x;
    logic [RB-1:0]           radius_y;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [OUT_W-1:0] x_right;
    logic signed [OUT_W-1:0] x_left;
    logic signed [OUT_W-1:0] y_lower;
    logic signed [OUT_W-1:0] y_upper;
    logic                    region;
    logic                    points_valid;
    logic                    last;

    // Tracer state: a 64-bit copy of the ellipse walk
    logic [63:0]  ctr_col;
    logic [63:0]  ctr_row;
    logic [63:0]  rx_sq;
    logic [63:0]  ry_sq;
    logic [63:0]  dx;
    logic [63:0]  dy;
    logic [63:0]  dec4;
    logic [63:0]  ry2x2;
    logic [63:0]  rx2y2;
    trace_phase_t trace_state;

    plot_t       expected_plots[$];
    stim_row_t   directed_rows[DIRECTED_ROWS];
    int          mismatches        = 0;
    int          transactions_sent = 0;
    int unsigned cycle_count       = 0;
    bit          steady            = 1'b0;

    midpoint_ellipse_rasterizer_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius_x     (radius_x),
        .radius_y     (radius_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .x_right      (x_right),
        .x_left       (x_left),
        .y_lower      (y_lower),
        .y_upper      (y_upper),
        .region       (region),
        .points_valid (points_valid),
        .last         (last)
    );

    always #2 clk = ~clk;

    // Hard stop: a hung handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Gap length for either side: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic plot_t plot_of(input int xr, input int xl, input int yl, input int yu,
                                      input logic rgn, input logic fin);
        plot_t p;
        p.xr  = OUT_W'(xr);
        p.xl  = OUT_W'(xl);
        p.yl  = OUT_W'(yl);
        p.yu  = OUT_W'(yu);
        p.rgn = rgn;
        p.pv  = 1'b1;
        p.fin = fin;
        return p;
    endfunction

    function automatic stim_row_t stim(input logic cmd, input int cx, input int cy,
                                       input int rx, input int ry,
                                       input logic typed, input plot_t want);
        stim_row_t s;
        s.cmd   = cmd;
        s.cx    = CB'(cx);
        s.cy    = CB'(cy);
        s.rx    = RB'(rx);
        s.ry    = RB'(ry);
        s.typed = typed;
        s.want  = want;
        return s;
    endfunction

    // Four symmetric points around the held centre; sums wrap to the port width.
    function automatic plot_t point_set(input logic rgn, input logic fin);
        plot_t p;
        p.xr  = OUT_W'(ctr_col + dx);
        p.xl  = OUT_W'(ctr_col - dx);
        p.yl  = OUT_W'(ctr_row + dy);
        p.yu  = OUT_W'(ctr_row - dy);
        p.rgn = rgn;
        p.pv  = 1'b1;
        p.fin = fin;
        return p;
    endfunction

    // Advance the tracer by one accepted transaction and return its point set.
    // The decision value is held times four so the half-pixel terms stay exact.
    function automatic plot_t trace_ellipse(input logic cmd,
                                            input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                                            input logic [RB-1:0] rx, input logic [RB-1:0] ry);
        logic [63:0] hx;
        logic [63:0] ym;
        logic        rgn;
        if (cmd == mer_pkg::CMD_START)
        begin
            ctr_col     = 64'(cx);
            ctr_row     = 64'(cy);
            rx_sq       = 64'(rx) * 64'(rx);
            ry_sq       = 64'(ry) * 64'(ry);
            dx          = '0;
            dy          = 64'(ry);
            ry2x2       = '0;
            rx2y2       = 2 * rx_sq * dy;
            dec4        = 4 * ry_sq - 4 * rx_sq * dy + rx_sq;
            // A flat ellipse is finished by its start point alone
            trace_state = (ry == '0) ? TRACE_IDLE : TRACE_REG1;
            return point_set(mer_pkg::REGION_ONE, ry == '0);
        end
        if (trace_state == TRACE_IDLE || dy == '0)
        begin
            trace_state = TRACE_IDLE;
            return IDLE_PLOT;
        end
        if (trace_state == TRACE_REG1 && ry2x2 < rx2y2)
        begin
            dx    += 1;
            ry2x2 += 2 * ry_sq;
            if (dec4[63])
                dec4 += 4 * (ry2x2 + ry_sq);
            else
            begin
                dy    -= 1;
                rx2y2 -= 2 * rx_sq;
                dec4  += 4 * (ry2x2 - rx2y2 + ry_sq);
            end
            rgn = mer_pkg::REGION_ONE;
        end
        else
        begin
            // Crossing into region 2: reload the decision value, then take
            // the first region 2 step in the same transaction.
            if (trace_state == TRACE_REG1)
            begin
                hx          = 2 * dx + 1;
                ym          = dy - 1;
                dec4        = hx * hx * ry_sq + 4 * ym * ym * rx_sq - 4 * rx_sq * ry_sq;
                trace_state = TRACE_REG2;
            end
            if (dec4 != '0 && !dec4[63])
            begin
                dy    -= 1;
                rx2y2 -= 2 * rx_sq;
                dec4  += 4 * (rx_sq - rx2y2);
            end
            else
            begin
                dx    += 1;
                dy    -= 1;
                ry2x2 += 2 * ry_sq;
                rx2y2 -= 2 * rx_sq;
                dec4  += 4 * (ry2x2 - rx2y2 + rx_sq);
            end
            rgn = mer_pkg::REGION_TWO;
        end
        if (dy == '0)
            trace_state = TRACE_IDLE;
        return point_set(rgn, dy == '0);
    endfunction

    // Offer one transaction, hold it until accepted, then log its expected plot.
    // Valid drops only across a gap, so back-to-back items keep it high.
    task automatic send_item(input logic cmd, input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                             input logic [RB-1:0] rx, input logic [RB-1:0] ry,
                             input logic typed, input plot_t want);
        int    gap;
        plot_t predicted;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        center_x <= cx;
        center_y <= cy;
        radius_x <= rx;
        radius_y <= ry;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = trace_ellipse(cmd, cx, cy, rx, ry);
        expected_plots.push_back(typed ? want : predicted);
        transactions_sent++;
    endtask

    // Step with junk in the unused payload fields, so those bits toggle too.
    task automatic send_step();
        send_item(mer_pkg::CMD_STEP, CB'($urandom), CB'($urandom), RB'($urandom),
                  RB'($urandom), 1'b0, IDLE_PLOT);
    endtask

    // Hold the sender until every outstanding point set has come back.
    // Drop valid first so the last transaction is not offered again.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_plots.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string what, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t %s: expected %0d, got %0d", $time, what, $signed(want),
                     $signed(got));
            mismatches++;
        end
    endtask

    // Result side: ready in bursts, stalls of random length, sometimes a long
    // stretch with no stall at all.
    initial
    begin
        int run;
        int hold;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                              : $urandom_range(1, 12);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            hold = pick_gap();
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // Compare each accepted result with the oldest expected plot.
    always @(posedge clk)
    begin
        plot_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_plots.size() == 0)
            begin
                $display("%0t result with none expected: x_right %0d x_left %0d %s %0d %s %0d",
                         $time, x_right, x_left, "y_lower", y_lower, "y_upper", y_upper);
                mismatches++;
            end
            else
            begin
                want = expected_plots.pop_front();
                check_field("x_right", want.xr, x_right);
                check_field("x_left", want.xl, x_left);
                check_field("y_lower", want.yl, y_lower);
                check_field("y_upper", want.yu, y_upper);
                check_field("region", OUT_W'(want.rgn), OUT_W'(region));
                check_field("points_valid", OUT_W'(want.pv), OUT_W'(points_valid));
                check_field("last", OUT_W'(want.fin), OUT_W'(last));
            end
        end
    end

    initial
    begin
        int          kind;
        int          steps_left;
        bit          drained_once;
        logic [RB-1:0] rx;
        logic [RB-1:0] ry;

        drained_once = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = mer_pkg::CMD_START;
        center_x     = '0;
        center_y     = '0;
        radius_x     = '0;
        radius_y     = '0;

        // Directed table. Typed rows are the obvious ones: a step with nothing
        // running, and the top and bottom points of a fresh start.
        // step straight after reset: all zero
        directed_rows[0]  = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b1, IDLE_PLOT);
        // unit circle at the origin: finishes inside region 1
        directed_rows[1]  = stim(mer_pkg::CMD_START, 0, 0, 1, 1, 1'b1,
                                 plot_of(0, 0, 1, -1, mer_pkg::REGION_ONE, 1'b0));
        directed_rows[2]  = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, IDLE_PLOT);
        directed_rows[3]  = stim(mer_pkg::CMD_STEP, 4095, 4095, 2047, 2047, 1'b1, IDLE_PLOT);
        // widest radii on the far column, nearest row: negative upper row
        directed_rows[4]  = stim(mer_pkg::CMD_START, 4095, 0, 2047, 2047, 1'b1,
                                 plot_of(4095, 4095, 2047, -2047, mer_pkg::REGION_ONE, 1'b0));
        directed_rows[5]  = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, IDLE_PLOT);
        directed_rows[6]  = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, IDLE_PLOT);
        directed_rows[7]  = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, IDLE_PLOT);
        // zero horizontal radius: straight into region 2, a vertical line
        directed_rows[8]  = stim(mer_pkg::CMD_START, 100, 200, 0, 5, 1'b1,
                                 plot_of(100, 100, 205, 195, mer_pkg::REGION_ONE, 1'b0));
        directed_rows[9]  = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, IDLE_PLOT);
        directed_rows[10] = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, IDLE_PLOT);
        directed_rows[11] = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, IDLE_PLOT);
        directed_rows[12] = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, IDLE_PLOT);
        directed_rows[13] = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, IDLE_PLOT);
        directed_rows[14] = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b1, IDLE_PLOT);
        // zero vertical radius: the start point is the whole ellipse
        directed_rows[15] = stim(mer_pkg::CMD_START, 10, 10, 5, 0, 1'b1,
                                 plot_of(10, 10, 10, 10, mer_pkg::REGION_ONE, 1'b1));
        directed_rows[16] = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b1, IDLE_PLOT);
        // tall narrow ellipse: crosses into region 2 on its second step
        directed_rows[17] = stim(mer_pkg::CMD_START, 50, 60, 1, 3, 1'b1,
                                 plot_of(50, 50, 63, 57, mer_pkg::REGION_ONE, 1'b0));
        directed_rows[18] = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, IDLE_PLOT);
        directed_rows[19] = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, IDLE_PLOT);
        // restart while the previous ellipse is still running
        directed_rows[20] = stim(mer_pkg::CMD_START, 2000, 4095, 8, 2, 1'b1,
                                 plot_of(2000, 2000, 4097, 4093, mer_pkg::REGION_ONE, 1'b0));
        directed_rows[21] = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, IDLE_PLOT);
        directed_rows[22] = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, IDLE_PLOT);
        directed_rows[23] = stim(mer_pkg::CMD_STEP, 0, 0, 0, 0, 1'b0, IDLE_PLOT);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].cx, directed_rows[i].cy,
                      directed_rows[i].rx, directed_rows[i].ry,
                      directed_rows[i].typed, directed_rows[i].want);

        // Random part: mostly whole ellipses with random centre and radii,
        // some cut short by the next start, plus stray steps as noise.
        while (transactions_sent < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if (!drained_once && transactions_sent >= DIRECTED_ROWS + RANDOM_ITEMS / 2)
            begin
                drain_results();
                drained_once = 1'b1;
            end
            else if ($urandom_range(0, 49) == 0)
                drain_results();

            kind = $urandom_range(0, 99);
            if (kind < 6)
                send_step();
            else
            begin
                // Keep most ellipses small; big ones are always aborted early
                if (kind < 80)
                begin
                    rx = RB'($urandom_range(0, 24));
                    ry = RB'($urandom_range(0, 24));
                end
                else if (kind < 94)
                begin
                    rx = RB'($urandom_range(1, 100));
                    ry = RB'($urandom_range(1, 100));
                end
                else
                begin
                    rx = RB'($urandom_range(256, 2047));
                    ry = RB'($urandom_range(256, 2047));
                end
                steps_left = (kind >= 94 || $urandom_range(0, 4) == 0) ?
                             $urandom_range(0, 40) : 32'h3fff_ffff;
                send_item(mer_pkg::CMD_START, CB'($urandom_range(0, 4095)),
                          CB'($urandom_range(0, 4095)), rx, ry, 1'b0, IDLE_PLOT);
                while (trace_state != TRACE_IDLE && steps_left > 0 &&
                       transactions_sent < DIRECTED_ROWS + RANDOM_ITEMS)
                begin
                    send_step();
                    steps_left--;
                end
                // Occasionally step past the end of the ellipse
                if ($urandom_range(0, 3) == 0)
                    send_step();
            end
        end

        in_valid <= 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
